FILE: rtl/core/ccts_pkg.sv
`default_nettype none

package ccts_pkg;

  localparam int COUNTER_BITS_DEF = 32;
  localparam int WRAP_W           = 32;

  localparam int CPS_W    = 30;
  localparam int CPM_W    = 20;
  localparam int CPU_W    = 10;
  localparam int CFG_W    = 30;
  localparam int CFG_IDX_W = 2;

  localparam logic [CPS_W-1:0] CPS_RST = 30'd1000000;
  localparam logic [CPM_W-1:0] CPM_RST = 20'd1000;
  localparam logic [CPU_W-1:0] CPU_RST = 10'd1;

  localparam int SAMPLE_W = 32;
  localparam int SEC_W    = 45;
  localparam int SMALL_W  = 10;
  localparam int TOTMIC_W = 64;

  localparam int OUT_FIELDS_W = SEC_W + 2 * SMALL_W + TOTMIC_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // shift-add multiplier constant: total_micros = (s * 1000 + ms) * 1000 + us
  localparam int               MUL_K_W = 10;
  localparam logic [MUL_K_W-1:0] MUL_K = 10'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPS = 2'd0,
    CFG_CPM = 2'd1,
    CFG_CPU = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_S,
    ST_DIV_MS,
    ST_DIV_US,
    ST_MUL_A,
    ST_MUL_B,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/ccts_div.sv
`default_nettype none

module ccts_div #(
  parameter int TOTAL_W = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [TOTAL_W-1:0]          dividend_i,
  input  wire logic [ccts_pkg::CPS_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [TOTAL_W-1:0]               quot_o,
  output logic [TOTAL_W-1:0]               rem_o
);

  localparam int DW   = ccts_pkg::CPS_W;
  localparam int CntW = $clog2(TOTAL_W);

  logic               busy_q, done_q, zdiv_q;
  logic [CntW-1:0]    cnt_q;
  logic [TOTAL_W-1:0] num_q, num_d;
  logic [DW-1:0]      dvs_q;
  logic [DW-1:0]      rem_q, rem_d;
  logic [DW:0]        trial;
  logic               ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_q, num_q[TOTAL_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
    num_d = {num_q[TOTAL_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= divisor_i != '0;
      done_q <= divisor_i == '0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(TOTAL_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      dvs_q  <= divisor_i;
      rem_q  <= '0;
      zdiv_q <= divisor_i == '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  // zero divisor: all-ones quotient, dividend left in num_q as remainder
  assign done_o = done_q;
  assign quot_o = zdiv_q ? '1 : num_q;
  assign rem_o  = zdiv_q ? num_q : TOTAL_W'(rem_q);

endmodule

`default_nettype wire

FILE: rtl/core/ccts_mul.sv
`default_nettype none

module ccts_mul (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [ccts_pkg::TOTMIC_W-1:0]     x_i,
  input  wire logic [ccts_pkg::SMALL_W-1:0]      addend_i,
  output logic                                   done_o,
  output logic [ccts_pkg::TOTMIC_W-1:0]          prod_o
);

  localparam int W  = ccts_pkg::TOTMIC_W;
  localparam int KW = ccts_pkg::MUL_K_W;

  logic          busy_q, done_q;
  logic [KW-1:0] k_q;
  logic [W-1:0]  xs_q, p_q;

  // p = x * MUL_K + addend, one constant bit per cycle, modulo 2^W
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      k_q    <= ccts_pkg::MUL_K;
    end else if (busy_q) begin
      k_q <= k_q >> 1;
      if ((k_q >> 1) == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xs_q <= x_i;
      p_q  <= W'(addend_i);
    end else if (busy_q) begin
      xs_q <= xs_q << 1;
      if (k_q[0]) begin
        p_q <= p_q + xs_q;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/core/cycle_count_time_splitter_top.sv
// Extends a free-running COUNTER_BITS-bit cycle counter to a wider total and
// splits it into seconds, millisecond and microsecond remainders plus the
// total in microseconds. Each request carries a counter sample; a sample below
// the previous one counts a wrap. A mode 0 request yields no result. A mode 1
// request runs three divisions one after another on one shared divider that
// retires one quotient bit per cycle, then two shift-add passes on the
// multiplier form the microsecond total. The result waits in an output
// register while the next request is taken. The user must write the divisor
// registers through the config port only while the block is idle; the block
// itself does not enforce this. A zero divisor gives an all-ones quotient,
// and oversized quotients saturate.
`default_nettype none

module cycle_count_time_splitter_top #(
  parameter int COUNTER_BITS = ccts_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [ccts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [ccts_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [ccts_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // counter_sample
  input  wire logic                               s_axis_tuser,  // mode
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // seconds, millis, micros, total_micros, zero pad
  output logic [ccts_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

  localparam int TotalW  = ccts_pkg::WRAP_W + COUNTER_BITS;
  localparam int CpsW    = ccts_pkg::CPS_W;
  localparam int SecW    = ccts_pkg::SEC_W;
  localparam int SmallW  = ccts_pkg::SMALL_W;
  localparam int TotMicW = ccts_pkg::TOTMIC_W;
  localparam int PadW    = ccts_pkg::OUT_TDATA_W - ccts_pkg::OUT_FIELDS_W;

  ccts_pkg::state_e state_q, state_d;

  logic [ccts_pkg::CPS_W-1:0]  cps_q;
  logic [ccts_pkg::CPM_W-1:0]  cpm_q;
  logic [ccts_pkg::CPU_W-1:0]  cpu_q;
  logic [ccts_pkg::WRAP_W-1:0] wrap_q, wrap_new;
  logic [COUNTER_BITS-1:0]     last_q, sample;
  logic [TotalW-1:0]           total;

  logic                s_fire, m_fire;
  logic                div_start, div_done;
  logic [TotalW-1:0]   div_dividend, div_quot, div_rem;
  logic [CpsW-1:0]     div_divisor;
  logic                mul_start, mul_done;
  logic [TotMicW-1:0]  mul_x, mul_p;
  logic [SmallW-1:0]   mul_addend;

  logic [SecW-1:0]     sec_q, sec_sat;
  logic [SmallW-1:0]   ms_q, us_q, small_sat;
  logic [TotMicW-1:0]  tot_q;
  logic                out_load;
  logic                ovalid_q;
  logic [SecW-1:0]     o_sec_q;
  logic [SmallW-1:0]   o_ms_q, o_us_q;
  logic [TotMicW-1:0]  o_tot_q;

  assign s_axis_tready = state_q == ccts_pkg::ST_IDLE;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  assign sample   = s_axis_tdata[COUNTER_BITS-1:0];
  assign wrap_new = (sample < last_q) ? wrap_q + 1'b1 : wrap_q;
  assign total    = {wrap_new, sample};

  assign sec_sat   = (|div_quot[TotalW-1:SecW]) ? '1 : div_quot[SecW-1:0];
  assign small_sat = (|div_quot[TotalW-1:SmallW]) ? '1 : div_quot[SmallW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q <= ccts_pkg::CPS_RST;
      cpm_q <= ccts_pkg::CPM_RST;
      cpu_q <= ccts_pkg::CPU_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ccts_pkg::CFG_CPS: cps_q <= cfg_wdata_i[ccts_pkg::CPS_W-1:0];
        ccts_pkg::CFG_CPM: cpm_q <= cfg_wdata_i[ccts_pkg::CPM_W-1:0];
        ccts_pkg::CFG_CPU: cpu_q <= cfg_wdata_i[ccts_pkg::CPU_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= '0;
      last_q <= '0;
    end else if (s_fire) begin
      wrap_q <= wrap_new;
      last_q <= sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = div_rem;
    div_divisor  = cps_q;
    mul_start    = 1'b0;
    mul_x        = mul_p;
    mul_addend   = us_q;
    out_load     = 1'b0;
    case (state_q)
      ccts_pkg::ST_IDLE: begin
        div_dividend = total;
        if (s_fire && s_axis_tuser) begin
          div_start = 1'b1;
          state_d   = ccts_pkg::ST_DIV_S;
        end
      end
      ccts_pkg::ST_DIV_S: begin
        div_divisor = CpsW'(cpm_q);
        if (div_done) begin
          div_start = 1'b1;
          state_d   = ccts_pkg::ST_DIV_MS;
        end
      end
      ccts_pkg::ST_DIV_MS: begin
        div_divisor = CpsW'(cpu_q);
        if (div_done) begin
          div_start = 1'b1;
          state_d   = ccts_pkg::ST_DIV_US;
        end
      end
      ccts_pkg::ST_DIV_US: begin
        mul_x      = TotMicW'(sec_q);
        mul_addend = ms_q;
        if (div_done) begin
          mul_start = 1'b1;
          state_d   = ccts_pkg::ST_MUL_A;
        end
      end
      ccts_pkg::ST_MUL_A: begin
        if (mul_done) begin
          mul_start = 1'b1;
          state_d   = ccts_pkg::ST_MUL_B;
        end
      end
      ccts_pkg::ST_MUL_B: begin
        if (mul_done) begin
          state_d = ccts_pkg::ST_OUT;
        end
      end
      ccts_pkg::ST_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ccts_pkg::ST_IDLE;
        end
      end
      default: state_d = ccts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (div_done && state_q == ccts_pkg::ST_DIV_S) begin
      sec_q <= sec_sat;
    end
    if (div_done && state_q == ccts_pkg::ST_DIV_MS) begin
      ms_q <= small_sat;
    end
    if (div_done && state_q == ccts_pkg::ST_DIV_US) begin
      us_q <= small_sat;
    end
    if (mul_done && state_q == ccts_pkg::ST_MUL_B) begin
      tot_q <= mul_p;
    end
    if (out_load) begin
      o_sec_q <= sec_q;
      o_ms_q  <= ms_q;
      o_us_q  <= us_q;
      o_tot_q <= tot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (out_load) begin
      ovalid_q <= 1'b1;
    end else if (m_fire) begin
      ovalid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, o_tot_q, o_us_q, o_ms_q, o_sec_q};

  ccts_div #(
    .TOTAL_W(TotalW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  ccts_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .addend_i(mul_addend),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

endmodule

`default_nettype wire
